// ----- rtl/igtp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// igtp_pkg: shared types and constants for IMU/GNSS timestamp pairing
// Event codes, register indexes, reset values and stream word layout.
// ---------------------------------------------------------------------------
package igtp_pkg;

  // Event codes carried in the low bits of the input word
  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_FIX    = 3'd1,
    OP_EVAL   = 3'd2,
    OP_PAIR   = 3'd3,
    OP_RECORD = 3'd4
  } opcode_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_INIT_PERIOD = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [1:0] CFG_FILTER      = 2'd2;

  // Register reset values
  localparam logic [31:0] INIT_PERIOD_RST = 32'd10;
  localparam logic [15:0] TIMEOUT_RST     = 16'd50;
  localparam logic        FILTER_RST      = 1'b1;

  // Stream word widths (packed fields, padded to whole bytes)
  localparam int unsigned IN_W  = 72;
  localparam int unsigned OUT_W = 264;

  // Commands into the statistics unit
  typedef struct packed {
    logic        record;
    logic        stale;
    logic [31:0] delta;
  } stats_cmd_t;

  // Statistics as seen after the current event
  typedef struct packed {
    logic        seen;
    logic [31:0] min_d;
    logic [31:0] max_d;
    logic [63:0] sum;
    logic [31:0] count;
    logic [31:0] stale;
  } stats_t;

endpackage

// ----- rtl/imu_gnss_timestamp_pairing_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imu_gnss_timestamp_pairing_top: IMU/GNSS timestamp pairing
// Tracks IMU sample times and a smoothed sample period, holds a pending GNSS
// fix until a new sample or timeout, and keeps pairing delta statistics.
// ---------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_axis    in   s_tvalid/s_tready    s_tdata: opcode, now_ms, delta_in
//  m_axis    out  m_tvalid/m_tready    m_tdata: decision, period, statistics
//  cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word in, one word out; a word is taken every cycle that the output register
// can take it, with its result in the output register on the following cycle.
// The only limit on rate is the single output register: input is taken when
// that register is empty or being drained in the same cycle.
// Reset (rst, synchronous) clears all state; configuration returns to
// initial_period_ms = 10, timeout_ms = 50, filter_stale = 1.
// Neither the input nor configuration writes are accepted while rst is high;
// out of reset, configuration writes are always accepted.
// ---------------------------------------------------------------------------
module imu_gnss_timestamp_pairing_top (
  input  logic                         clk,
  input  logic                         rst,
  // opcode [2:0], now_ms [34:3], delta_in [66:35], zero [71:67]
  input  logic [igtp_pkg::IN_W-1:0]    s_tdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // pair_ok [0], should_send [1], valid_for_stats [2], delta_ms [34:3],
  // period_ms [66:35], stats_valid [67], min_delta [99:68],
  // max_delta [131:100], delta_sum [195:132], delta_count [227:196],
  // stale_count [259:228], zero [263:260]
  output logic [igtp_pkg::OUT_W-1:0]   m_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);
  import igtp_pkg::*;

  // Configuration registers
  logic [31:0] init_period;
  logic [15:0] timeout;
  logic        filter_stale;

  // Tracking state
  logic [31:0] last_sample_time, last_sample_time_next;
  logic        have_sample, have_sample_next;
  logic [31:0] period_est, period_est_next;
  logic        period_measured, period_measured_next;
  logic [31:0] sample_counter, sample_counter_next;
  logic [31:0] fix_time, fix_time_next;
  logic [31:0] counter_at_fix, counter_at_fix_next;
  logic        pending, pending_next;

  // Output register
  logic [OUT_W-1:0] res_data;
  logic             res_valid;

  // Event decode
  logic        in_acc;
  opcode_t     op;
  logic [31:0] now_ms;
  logic [31:0] delta_in;
  logic [31:0] cur_period;
  logic [31:0] age;
  logic [33:0] smooth_acc;
  logic        fresh;
  logic        timed;
  logic        usable;
  logic [32:0] stale_limit;
  logic        pair_hit;
  logic        pair_ok, should_send, valid_stats;
  logic [31:0] delta_ms;
  logic [31:0] period_out;
  stats_cmd_t  scmd;
  stats_t      stats_next;

  assign cfg_ready = !rst;
  assign s_tready  = !rst && (!res_valid || m_tready);
  assign in_acc    = s_tvalid && s_tready;
  assign m_tvalid  = res_valid;
  assign m_tdata   = res_data;

  assign op       = opcode_t'(s_tdata[2:0]);
  assign now_ms   = s_tdata[34:3];
  assign delta_in = s_tdata[66:35];

  // Shared terms
  assign cur_period  = period_measured ? period_est : init_period;
  assign age         = now_ms - last_sample_time;
  assign smooth_acc  = {2'b00, cur_period} + {1'b0, cur_period, 1'b0} + {2'b00, age};
  assign fresh       = sample_counter != counter_at_fix;
  assign timed       = (now_ms - fix_time) >= {16'd0, timeout};
  assign stale_limit = {1'b0, cur_period} + {17'd0, timeout};
  assign usable      = have_sample && (fresh || !filter_stale || {1'b0, age} <= stale_limit);
  assign pair_hit    = have_sample && (age <= {1'b0, cur_period[31:1]});

  // Event decision and next state
  always_comb begin
    last_sample_time_next = last_sample_time;
    have_sample_next      = have_sample;
    period_est_next       = period_est;
    period_measured_next  = period_measured;
    sample_counter_next   = sample_counter;
    fix_time_next         = fix_time;
    counter_at_fix_next   = counter_at_fix;
    pending_next          = pending;
    pair_ok               = 1'b0;
    should_send           = 1'b0;
    valid_stats           = 1'b0;
    delta_ms              = '0;
    scmd.record           = 1'b0;
    scmd.stale            = 1'b0;
    scmd.delta            = delta_in;
    unique case (op)
      OP_SAMPLE: begin
        if (have_sample) begin
          period_est_next      = smooth_acc[33:2];
          period_measured_next = 1'b1;
        end
        last_sample_time_next = now_ms;
        have_sample_next      = 1'b1;
        sample_counter_next   = sample_counter + 32'd1;
      end
      OP_FIX: begin
        fix_time_next       = now_ms;
        counter_at_fix_next = sample_counter;
        pending_next        = 1'b1;
      end
      OP_EVAL: begin
        if (pending && (fresh || timed)) begin
          should_send  = 1'b1;
          pending_next = 1'b0;
          if (usable) begin
            valid_stats = 1'b1;
            delta_ms    = last_sample_time - fix_time;
          end else begin
            scmd.stale = 1'b1;
          end
        end
      end
      OP_PAIR: begin
        if (pair_hit) begin
          pair_ok      = 1'b1;
          delta_ms     = last_sample_time - now_ms;
          pending_next = 1'b0;
        end
      end
      OP_RECORD: begin
        scmd.record = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign period_out = period_measured_next ? period_est_next : init_period;

  igtp_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .en         (in_acc),
    .cmd        (scmd),
    .stats_next (stats_next)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init_period  <= INIT_PERIOD_RST;
      timeout      <= TIMEOUT_RST;
      filter_stale <= FILTER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INIT_PERIOD: init_period  <= cfg_data;
        CFG_TIMEOUT:     timeout      <= cfg_data[15:0];
        CFG_FILTER:      filter_stale <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Tracking state update
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time <= '0;
      have_sample      <= 1'b0;
      period_est       <= '0;
      period_measured  <= 1'b0;
      sample_counter   <= '0;
      fix_time         <= '0;
      counter_at_fix   <= '0;
      pending          <= 1'b0;
    end else if (in_acc) begin
      last_sample_time <= last_sample_time_next;
      have_sample      <= have_sample_next;
      period_est       <= period_est_next;
      period_measured  <= period_measured_next;
      sample_counter   <= sample_counter_next;
      fix_time         <= fix_time_next;
      counter_at_fix   <= counter_at_fix_next;
      pending          <= pending_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_acc) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_data <= {4'd0, stats_next.stale, stats_next.count, stats_next.sum,
                   stats_next.max_d, stats_next.min_d, stats_next.seen,
                   period_out, delta_ms, valid_stats, should_send, pair_ok};
    end
  end

  // A taken word always leaves a result behind
  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> res_valid)
    else $error("no result after accepted word");

  // A sample event leaves a sample on record
  a_sample_seen: assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == OP_SAMPLE) |=> have_sample)
    else $error("sample not recorded");

  // A successful immediate pair or a release clears the pending fix
  a_pending_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (pair_ok || should_send)) |=> !pending)
    else $error("pending fix not cleared");

  // A usable release is always a release
  a_valid_implies_send: assert property (@(posedge clk) disable iff (rst)
    (in_acc && valid_stats) |=> (res_data[2] && res_data[1]))
    else $error("usable pairing without release");

  // Recording a delta marks the statistics valid
  a_record_seen: assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == OP_RECORD) |=> res_data[67])
    else $error("statistics not valid after record");

endmodule

// ----- rtl/igtp_stats.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// igtp_stats: delta statistics and stale counter
// Keeps min, max, sum and count of recorded deltas plus the stale count,
// and presents the values that hold after the current event.
// ---------------------------------------------------------------------------
module igtp_stats (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  igtp_pkg::stats_cmd_t cmd,
  output igtp_pkg::stats_t     stats_next
);
  import igtp_pkg::*;

  logic        seen;
  logic [31:0] min_d;
  logic [31:0] max_d;
  logic [63:0] sum;
  logic [31:0] count;
  logic [31:0] stale;
  logic [63:0] delta_wide;

  assign delta_wide = {{32{cmd.delta[31]}}, cmd.delta};

  // Next statistics for this event
  always_comb begin
    stats_next.seen  = seen;
    stats_next.min_d = min_d;
    stats_next.max_d = max_d;
    stats_next.sum   = sum;
    stats_next.count = count;
    stats_next.stale = stale;
    if (en && cmd.record) begin
      if (!seen) begin
        stats_next.seen  = 1'b1;
        stats_next.min_d = cmd.delta;
        stats_next.max_d = cmd.delta;
        stats_next.sum   = delta_wide;
        stats_next.count = 32'd1;
      end else begin
        if ($signed(cmd.delta) < $signed(min_d)) stats_next.min_d = cmd.delta;
        if ($signed(cmd.delta) > $signed(max_d)) stats_next.max_d = cmd.delta;
        stats_next.sum   = sum + delta_wide;
        stats_next.count = count + 32'd1;
      end
    end
    if (en && cmd.stale) begin
      stats_next.stale = stale + 32'd1;
    end
  end

  // Statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= 1'b0;
      min_d <= '0;
      max_d <= '0;
      sum   <= '0;
      count <= '0;
      stale <= '0;
    end else if (en) begin
      seen  <= stats_next.seen;
      min_d <= stats_next.min_d;
      max_d <= stats_next.max_d;
      sum   <= stats_next.sum;
      count <= stats_next.count;
      stale <= stats_next.stale;
    end
  end

endmodule
